/* rtl/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; clock i_clk and reset i_rst_n are taken from the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define EIGT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EIGT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/eigt_pkg.sv */
// package for the encoder index gap tracker: widths, reset values, codes, types
// no dependencies
package eigt_pkg;

    localparam int HISTORY_DEPTH_DEF = 4;

    localparam int CAP_W      = 16;
    localparam int MS_W       = 32;
    localparam int CYC_W      = 32;
    localparam int HOLES_W    = 16;
    localparam int TMO_W      = 8;
    localparam int CPU_W      = 10;
    localparam int ROT_W      = 32;
    localparam int DIV_W      = 32;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [HOLES_W-1:0] HOLES_RST = 16'd32;
    localparam logic [TMO_W-1:0]   TMO_RST   = 8'd5;
    localparam logic [CPU_W-1:0]   CPU_RST   = 10'd72;

    typedef enum logic [1:0] {
        REG_HOLES      = 2'd0,
        REG_TIMEOUT    = 2'd1,
        REG_CYC_PER_US = 2'd2
    } t_reg_idx;

    typedef enum logic {
        OP_CAPTURE = 1'b0,
        OP_TICK    = 1'b1
    } t_op;

    typedef struct packed {
        logic [HOLES_W-1:0] holes_per_turn;
        logic [TMO_W-1:0]   stop_timeout_ms;
        logic [CPU_W-1:0]   cycles_per_us;
    } t_cfg;

    typedef struct packed {
        logic               gap_found;
        logic [HOLES_W-1:0] event_number;
        logic [CAP_W-1:0]   period_ticks;
        logic               sync_fail;
        logic               mirror_stopped;
        logic [ROT_W-1:0]   rotation_period_us;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_REC,
        S_AVG,
        S_CMP,
        S_GAP,
        S_ROT_RUN,
        S_ROT_END,
        S_OUT
    } t_state;

    typedef struct packed {
        logic take_item;
        logic tick;
        logic record;
        logic avg_start;
        logic compare;
        logic gap_apply;
        logic rot_store;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic gap;
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/eigt_chan_if.sv */
// valid/ready channel interfaces for input items and results
// depends on eigt_pkg
interface eigt_in_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [eigt_pkg::CAP_W-1:0]   capture_value;
    logic [eigt_pkg::MS_W-1:0]    now_ms;
    logic [eigt_pkg::CYC_W-1:0]   now_cycles;

    modport source (output valid, operation, capture_value, now_ms, now_cycles, input ready);
    modport sink   (input valid, operation, capture_value, now_ms, now_cycles, output ready);
endinterface

interface eigt_out_if;
    logic                         valid;
    logic                         ready;
    logic                         gap_found;
    logic [eigt_pkg::HOLES_W-1:0] event_number;
    logic [eigt_pkg::CAP_W-1:0]   period_ticks;
    logic                         sync_fail;
    logic                         mirror_stopped;
    logic [eigt_pkg::ROT_W-1:0]   rotation_period_us;

    modport source (output valid, gap_found, event_number, period_ticks, sync_fail,
                    mirror_stopped, rotation_period_us, input ready);
    modport sink   (input valid, gap_found, event_number, period_ticks, sync_fail,
                    mirror_stopped, rotation_period_us, output ready);
endinterface

/* rtl/eigt_regs.sv */
// apb configuration registers: holes per turn, stop timeout, cycles per microsecond
// depends on eigt_pkg
module eigt_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [eigt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [eigt_pkg::APB_DATA_W-1:0] pwdata,
    output logic [eigt_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output eigt_pkg::t_cfg                  o_cfg
);

    eigt_pkg::t_cfg r_cfg;
    logic [1:0]     w_index;
    logic           w_write;

    assign pready  = 1'b1;
    assign w_index = paddr[eigt_pkg::APB_ADDR_W-1:2];
    assign w_write = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.holes_per_turn  <= eigt_pkg::HOLES_RST;
            r_cfg.stop_timeout_ms <= eigt_pkg::TMO_RST;
            r_cfg.cycles_per_us   <= eigt_pkg::CPU_RST;
        end else if (w_write) begin
            case (w_index)
                eigt_pkg::REG_HOLES: begin
                    r_cfg.holes_per_turn <= pwdata[eigt_pkg::HOLES_W-1:0];
                end
                eigt_pkg::REG_TIMEOUT: begin
                    r_cfg.stop_timeout_ms <= pwdata[eigt_pkg::TMO_W-1:0];
                end
                eigt_pkg::REG_CYC_PER_US: begin
                    r_cfg.cycles_per_us <= pwdata[eigt_pkg::CPU_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_index)
            eigt_pkg::REG_HOLES: begin
                prdata = eigt_pkg::APB_DATA_W'(r_cfg.holes_per_turn);
            end
            eigt_pkg::REG_TIMEOUT: begin
                prdata = eigt_pkg::APB_DATA_W'(r_cfg.stop_timeout_ms);
            end
            eigt_pkg::REG_CYC_PER_US: begin
                prdata = eigt_pkg::APB_DATA_W'(r_cfg.cycles_per_us);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

/* rtl/eigt_ctrl.sv */
// controller state machine: sequences tick, record, average, compare, gap divide and output
// depends on eigt_pkg
module eigt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_op,
    input  eigt_pkg::t_dp_status i_status,
    output logic                 o_in_ready,
    output eigt_pkg::t_dp_cmd    o_cmd
);

    eigt_pkg::t_state r_state;
    eigt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eigt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            eigt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_op == eigt_pkg::OP_TICK) ? eigt_pkg::S_TICK
                                                             : eigt_pkg::S_REC;
                end
            end
            eigt_pkg::S_TICK:    n_state = eigt_pkg::S_OUT;
            eigt_pkg::S_REC:     n_state = eigt_pkg::S_AVG;
            eigt_pkg::S_AVG:     n_state = eigt_pkg::S_CMP;
            eigt_pkg::S_CMP: begin
                n_state = i_status.gap ? eigt_pkg::S_GAP : eigt_pkg::S_OUT;
            end
            eigt_pkg::S_GAP:     n_state = eigt_pkg::S_ROT_RUN;
            eigt_pkg::S_ROT_RUN: begin
                if (!i_status.div_busy) begin
                    n_state = eigt_pkg::S_ROT_END;
                end
            end
            eigt_pkg::S_ROT_END: n_state = eigt_pkg::S_OUT;
            eigt_pkg::S_OUT: begin
                if (i_status.out_free) begin
                    n_state = eigt_pkg::S_IDLE;
                end
            end
            default:             n_state = eigt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            eigt_pkg::S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.take_item = i_in_valid;
            end
            eigt_pkg::S_TICK:    o_cmd.tick      = 1'b1;
            eigt_pkg::S_REC:     o_cmd.record    = 1'b1;
            eigt_pkg::S_AVG:     o_cmd.avg_start = 1'b1;
            eigt_pkg::S_CMP:     o_cmd.compare   = 1'b1;
            eigt_pkg::S_GAP:     o_cmd.gap_apply = 1'b1;
            eigt_pkg::S_ROT_END: o_cmd.rot_store = 1'b1;
            eigt_pkg::S_OUT:     o_cmd.out_load  = i_status.out_free;
            default: begin
            end
        endcase
    end

endmodule

/* rtl/eigt_dp.sv */
// datapath: tracker state, period history with running sum and reciprocal average,
// bit-serial divider for the rotation period, result register; depends on eigt_pkg
module eigt_dp #(
    parameter int HISTORY_DEPTH = eigt_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  eigt_pkg::t_cfg               i_cfg,
    input  eigt_pkg::t_dp_cmd            i_cmd,
    output eigt_pkg::t_dp_status         o_status,
    input  logic [eigt_pkg::CAP_W-1:0]   i_capture_value,
    input  logic [eigt_pkg::MS_W-1:0]    i_now_ms,
    input  logic [eigt_pkg::CYC_W-1:0]   i_now_cycles,
    output logic                         o_res_valid,
    output eigt_pkg::t_result            o_res,
    input  logic                         i_res_ready
);

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int SUM_W  = eigt_pkg::CAP_W + SLOT_W;
    localparam int CNT_W  = $clog2(eigt_pkg::DIV_W + 1);
    localparam int CMP_W  = eigt_pkg::CAP_W + 3;
    localparam int DW     = eigt_pkg::DIV_W;

    // floor(sum / HISTORY_DEPTH) as (sum * ceil(2^sh / depth)) >> sh
    localparam int     RECIP_SH  = SUM_W + SLOT_W;
    localparam int     RECIP_W   = SUM_W + 1;
    localparam int     PROD_W    = SUM_W + RECIP_W;
    localparam longint RECIP_VAL = ((longint'(1) << RECIP_SH) + longint'(HISTORY_DEPTH) - 1)
                                   / longint'(HISTORY_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP_VAL);

    logic [eigt_pkg::CAP_W-1:0]   r_cap;
    logic [eigt_pkg::MS_W-1:0]    r_now_ms;
    logic [eigt_pkg::CYC_W-1:0]   r_now_cyc;
    logic [eigt_pkg::CAP_W-1:0]   r_period;
    logic                         r_gap;
    logic [eigt_pkg::CAP_W-1:0]   r_avg;

    logic [eigt_pkg::CAP_W-1:0]   r_last_capture;
    logic [eigt_pkg::CAP_W-1:0]   r_hist [HISTORY_DEPTH];
    logic [SLOT_W-1:0]            r_slot;
    logic [SUM_W-1:0]             r_sum;
    logic [eigt_pkg::HOLES_W-1:0] r_hole_count;
    logic [eigt_pkg::MS_W-1:0]    r_last_event_ms;
    logic [eigt_pkg::CYC_W-1:0]   r_last_gap_cycles;
    logic                         r_sync_fail;
    logic                         r_stopped;
    logic [eigt_pkg::ROT_W-1:0]   r_rotation;

    logic [DW-1:0]                r_rem;
    logic [DW-1:0]                r_quo;
    logic [DW-1:0]                r_div;
    logic [CNT_W-1:0]             r_div_cnt;

    eigt_pkg::t_result            r_res;
    logic                         r_res_valid;

    logic [eigt_pkg::CAP_W-1:0]   w_period;
    logic [DW:0]                  w_trial;
    logic [DW+1:0]                w_diff;
    logic                         w_ge;
    logic [PROD_W-1:0]            w_prod;
    logic [eigt_pkg::CAP_W-1:0]   w_avg;
    logic [CMP_W-1:0]             w_lhs;
    logic [CMP_W-1:0]             w_rhs;
    logic                         w_gap;
    logic                         w_out_free;

    assign w_period = r_cap - r_last_capture;

    // restoring divider step
    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_div};
    assign w_ge    = !w_diff[DW+1];

    assign w_prod = PROD_W'(r_sum) * PROD_W'(RECIP_M);
    assign w_avg  = w_prod[RECIP_SH +: eigt_pkg::CAP_W];
    assign w_lhs  = CMP_W'({r_period, 2'b00});
    assign w_rhs  = CMP_W'({r_avg, 2'b00}) + CMP_W'(r_avg);
    assign w_gap  = (w_lhs >= w_rhs);

    assign w_out_free = !r_res_valid || i_res_ready;

    assign o_status.div_busy = (r_div_cnt != '0);
    assign o_status.gap      = w_gap;
    assign o_status.out_free = w_out_free;
    assign o_res_valid       = r_res_valid;
    assign o_res             = r_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_cap     <= i_capture_value;
            r_now_ms  <= i_now_ms;
            r_now_cyc <= i_now_cycles;
            r_period  <= '0;
            r_gap     <= 1'b0;
        end else begin
            if (i_cmd.record) begin
                r_period <= w_period;
            end
            if (i_cmd.avg_start) begin
                r_avg <= w_avg;
            end
            if (i_cmd.compare) begin
                r_gap <= w_gap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_capture    <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
            r_slot            <= '0;
            r_sum             <= '0;
            r_hole_count      <= '0;
            r_last_event_ms   <= '0;
            r_last_gap_cycles <= '0;
            r_sync_fail       <= 1'b0;
            r_stopped         <= 1'b0;
            r_rotation        <= '0;
        end else begin
            if (i_cmd.record) begin
                r_last_capture  <= r_cap;
                r_hist[r_slot]  <= w_period;
                r_sum           <= r_sum - SUM_W'(r_hist[r_slot]) + SUM_W'(w_period);
                r_hole_count    <= r_hole_count + 1'b1;
                r_last_event_ms <= r_now_ms;
                if (r_slot == SLOT_W'(HISTORY_DEPTH - 1)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
            if (i_cmd.gap_apply) begin
                r_sync_fail       <= (r_hole_count != i_cfg.holes_per_turn);
                r_hole_count      <= eigt_pkg::HOLES_W'(1);
                r_last_gap_cycles <= r_now_cyc;
            end
            if (i_cmd.rot_store) begin
                r_rotation <= r_quo;
            end
            if (i_cmd.tick) begin
                r_stopped <= ((r_now_ms - r_last_event_ms) >
                              eigt_pkg::MS_W'(i_cfg.stop_timeout_ms));
            end
        end
    end

    // divider operands: elapsed cycles over cycles_per_us
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.gap_apply) begin
            r_div_cnt <= CNT_W'(DW);
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.gap_apply) begin
            r_rem <= '0;
            r_quo <= r_now_cyc - r_last_gap_cycles;
            r_div <= DW'(i_cfg.cycles_per_us);
        end else if (r_div_cnt != '0) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_res.gap_found          <= r_gap;
            r_res.event_number       <= r_hole_count;
            r_res.period_ticks       <= r_period;
            r_res.sync_fail          <= r_sync_fail;
            r_res.mirror_stopped     <= r_stopped;
            r_res.rotation_period_us <= r_rotation;
        end
    end

endmodule

/* rtl/encoder_index_gap_tracker.sv */
// a tick beat passes S_TICK and S_OUT after acceptance, a capture beat S_REC, S_AVG, S_CMP
// and S_OUT, an index gap also S_GAP, S_ROT_RUN and S_ROT_END; a stalled earlier result adds its wait
// the gap path runs the bit-serial divider for the rotation period: 32 steps
// one beat at a time: input ready is raised only in the idle state, which follows the result load
// reset: synchronous active-low i_rst_n clears history, counters, flags and config defaults
module encoder_index_gap_tracker #(
    parameter int HISTORY_DEPTH = eigt_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    eigt_in_if.sink                         i_in,
    eigt_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [eigt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [eigt_pkg::APB_DATA_W-1:0] pwdata,
    output logic [eigt_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    eigt_pkg::t_cfg       w_cfg;
    eigt_pkg::t_dp_cmd    w_cmd;
    eigt_pkg::t_dp_status w_status;
    eigt_pkg::t_result    w_res;
    logic                 w_in_ready;
    logic                 w_res_valid;

    eigt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    eigt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.operation),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    eigt_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_capture_value (i_in.capture_value),
        .i_now_ms        (i_in.now_ms),
        .i_now_cycles    (i_in.now_cycles),
        .o_res_valid     (w_res_valid),
        .o_res           (w_res),
        .i_res_ready     (o_out.ready)
    );

    assign i_in.ready               = w_in_ready;
    assign o_out.valid              = w_res_valid;
    assign o_out.gap_found          = w_res.gap_found;
    assign o_out.event_number       = w_res.event_number;
    assign o_out.period_ticks       = w_res.period_ticks;
    assign o_out.sync_fail          = w_res.sync_fail;
    assign o_out.mirror_stopped     = w_res.mirror_stopped;
    assign o_out.rotation_period_us = w_res.rotation_period_us;

endmodule

/* rtl/eigt_checker.sv */
// port-level checker for the tracker, attached by bind
// depends on eigt_pkg and assert_macros.svh
`include "assert_macros.svh"

module eigt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_out_gap_found,
    input logic [eigt_pkg::HOLES_W-1:0] i_out_event_number,
    input logic [eigt_pkg::CAP_W-1:0]   i_out_period_ticks,
    input logic                         i_out_sync_fail,
    input logic                         i_out_mirror_stopped,
    input logic [eigt_pkg::ROT_W-1:0]   i_out_rotation_period_us
);

    eigt_pkg::t_result w_payload;

    assign w_payload = {i_out_gap_found, i_out_event_number, i_out_period_ticks,
                        i_out_sync_fail, i_out_mirror_stopped, i_out_rotation_period_us};

    // a gap restarts the hole count
    `EIGT_ASSERT_SAME(a_gap_count_one, i_out_valid && i_out_gap_found, i_out_event_number == eigt_pkg::HOLES_W'(1), "gap beat without count restart")

    // one beat in flight
    `EIGT_ASSERT_NEXT(a_one_in_flight, i_in_valid && i_in_ready, !i_in_ready, "ready held after accept")

    `EIGT_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(w_payload), "stalled result changed")

endmodule

bind encoder_index_gap_tracker eigt_checker u_eigt_checker (
    .i_clk                    (i_clk),
    .i_rst_n                  (i_rst_n),
    .i_in_valid               (i_in.valid),
    .i_in_ready               (i_in.ready),
    .i_out_valid              (o_out.valid),
    .i_out_ready              (o_out.ready),
    .i_out_gap_found          (o_out.gap_found),
    .i_out_event_number       (o_out.event_number),
    .i_out_period_ticks       (o_out.period_ticks),
    .i_out_sync_fail          (o_out.sync_fail),
    .i_out_mirror_stopped     (o_out.mirror_stopped),
    .i_out_rotation_period_us (o_out.rotation_period_us)
);

/* sim/tb_encoder_index_gap_tracker.sv */
`timescale 1ns / 100ps
// testbench for encoder_index_gap_tracker: a directed table, then random encoder turns
// under three idle patterns; every result beat is checked against a typed table value or an in-bench tracker model
// depends on eigt_pkg, eigt_chan_if and encoder_index_gap_tracker
module tb_encoder_index_gap_tracker;

    localparam int HIST_N = eigt_pkg::HISTORY_DEPTH_DEF;
    localparam int SLOT_BITS = $clog2(HIST_N);
    localparam int SEG_ITEMS = 125;
    localparam int N_SEGS = 6;
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct {
        eigt_pkg::t_op              op;
        logic [eigt_pkg::CAP_W-1:0] cap;
        logic [eigt_pkg::MS_W-1:0]  ms;
        logic [eigt_pkg::CYC_W-1:0] cyc;
    } t_enc_beat;

    typedef enum { ROW_BEAT, ROW_REG } t_row_kind;

    typedef struct {
        t_row_kind         kind;
        t_enc_beat         beat;
        logic [1:0]        reg_idx;
        logic [31:0]       reg_data;
        bit                typed;
        eigt_pkg::t_result status;
    } t_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [eigt_pkg::APB_ADDR_W-1:0] paddr;
    logic [eigt_pkg::APB_DATA_W-1:0] pwdata;
    logic [eigt_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    eigt_in_if  in_if ();
    eigt_out_if out_if ();

    encoder_index_gap_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // tracker model state and its copy of the registers
    logic [eigt_pkg::HOLES_W-1:0] cfg_holes = eigt_pkg::HOLES_RST;
    logic [eigt_pkg::TMO_W-1:0]   cfg_tmo   = eigt_pkg::TMO_RST;
    logic [eigt_pkg::CPU_W-1:0]   cfg_cpu   = eigt_pkg::CPU_RST;

    logic [eigt_pkg::CAP_W-1:0]   mdl_last_cap  = '0;
    logic [eigt_pkg::CAP_W-1:0]   mdl_hist [HIST_N];
    logic [SLOT_BITS-1:0]         mdl_slot      = '0;
    logic [eigt_pkg::HOLES_W-1:0] mdl_holes     = '0;
    logic [eigt_pkg::MS_W-1:0]    mdl_last_ms   = '0;
    logic [eigt_pkg::CYC_W-1:0]   mdl_last_gap  = '0;
    logic                         mdl_sync      = 1'b0;
    logic                         mdl_stopped   = 1'b0;
    logic [eigt_pkg::ROT_W-1:0]   mdl_rot       = '0;

    eigt_pkg::t_result status_due [$];
    t_row              dir_rows [$];
    int                errors = 0;
    int                src_idle_pct = 27;
    int                snk_idle_pct = 52;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic eigt_pkg::t_result next_status(input t_enc_beat b);
        eigt_pkg::t_result          r;
        logic [eigt_pkg::CAP_W-1:0] per;
        logic [eigt_pkg::MS_W-1:0]  idle_ms;
        logic [eigt_pkg::CYC_W-1:0] elapsed;
        int                         sum;
        logic                       gap;
        per = '0;
        gap = 1'b0;
        if (b.op == eigt_pkg::OP_CAPTURE) begin
            per = b.cap - mdl_last_cap;
            mdl_last_cap = b.cap;
            mdl_holes = mdl_holes + 1'b1;
            mdl_last_ms = b.ms;
            mdl_hist[mdl_slot] = per;
            mdl_slot = (int'(mdl_slot) == HIST_N - 1) ? '0 : mdl_slot + 1'b1;
            sum = 0;
            for (int i = 0; i < HIST_N; i++) sum += int'(mdl_hist[i]);
            gap = (4 * int'(per)) >= (5 * (sum / HIST_N));
            if (gap) begin
                elapsed = b.cyc - mdl_last_gap;
                mdl_sync = (mdl_holes != cfg_holes);
                mdl_holes = eigt_pkg::HOLES_W'(1);
                mdl_rot = (cfg_cpu == '0) ? '1 : elapsed / {22'd0, cfg_cpu};
                mdl_last_gap = b.cyc;
            end
        end else begin
            idle_ms = b.ms - mdl_last_ms;
            mdl_stopped = (idle_ms > {24'd0, cfg_tmo});
        end
        r.gap_found = gap;
        r.event_number = mdl_holes;
        r.period_ticks = per;
        r.sync_fail = mdl_sync;
        r.mirror_stopped = mdl_stopped;
        r.rotation_period_us = mdl_rot;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s expected 0x%0h actual 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic void add_beat(input eigt_pkg::t_op op,
                                     input logic [eigt_pkg::CAP_W-1:0] cap,
                                     input logic [eigt_pkg::MS_W-1:0] ms,
                                     input logic [eigt_pkg::CYC_W-1:0] cyc);
        t_row r;
        r.kind = ROW_BEAT;
        r.beat.op = op;
        r.beat.cap = cap;
        r.beat.ms = ms;
        r.beat.cyc = cyc;
        r.reg_idx = '0;
        r.reg_data = '0;
        r.typed = 1'b0;
        r.status = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_typed(input eigt_pkg::t_op op,
                                      input logic [eigt_pkg::CAP_W-1:0] cap,
                                      input logic [eigt_pkg::MS_W-1:0] ms,
                                      input logic [eigt_pkg::CYC_W-1:0] cyc,
                                      input eigt_pkg::t_result want);
        add_beat(op, cap, ms, cyc);
        dir_rows[$].typed = 1'b1;
        dir_rows[$].status = want;
    endfunction

    function automatic void add_reg(input logic [1:0] idx, input logic [31:0] data);
        t_row r;
        r.kind = ROW_REG;
        r.beat.op = eigt_pkg::OP_CAPTURE;
        r.beat.cap = '0;
        r.beat.ms = '0;
        r.beat.cyc = '0;
        r.reg_idx = idx;
        r.reg_data = data;
        r.typed = 1'b0;
        r.status = '0;
        dir_rows.push_back(r);
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            eigt_pkg::REG_HOLES:      cfg_holes = data[eigt_pkg::HOLES_W-1:0];
            eigt_pkg::REG_TIMEOUT:    cfg_tmo = data[eigt_pkg::TMO_W-1:0];
            eigt_pkg::REG_CYC_PER_US: cfg_cpu = data[eigt_pkg::CPU_W-1:0];
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_beat(input t_enc_beat b, input bit typed,
                             input eigt_pkg::t_result want);
        eigt_pkg::t_result mdl;
        if ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_if.valid <= 1'b1;
        in_if.operation <= b.op;
        in_if.capture_value <= b.cap;
        in_if.now_ms <= b.ms;
        in_if.now_cycles <= b.cyc;
        do @(posedge i_clk); while (!in_if.ready);
        mdl = next_status(b);
        status_due.push_back(typed ? want : mdl);
    endtask

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        eigt_pkg::t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (status_due.size() == 0) begin
                $error("result beat with no expectation waiting");
                errors++;
            end else begin
                want = status_due.pop_front();
                check_field("gap_found", 32'(want.gap_found), 32'(out_if.gap_found));
                check_field("event_number", 32'(want.event_number),
                            32'(out_if.event_number));
                check_field("period_ticks", 32'(want.period_ticks),
                            32'(out_if.period_ticks));
                check_field("sync_fail", 32'(want.sync_fail), 32'(out_if.sync_fail));
                check_field("mirror_stopped", 32'(want.mirror_stopped),
                            32'(out_if.mirror_stopped));
                check_field("rotation_period_us", want.rotation_period_us,
                            out_if.rotation_period_us);
            end
        end
    end

    initial begin
        t_enc_beat                    b;
        logic [eigt_pkg::HOLES_W-1:0] h;
        logic [eigt_pkg::TMO_W-1:0]   t;
        logic [eigt_pkg::CPU_W-1:0]   c;
        logic [eigt_pkg::CAP_W-1:0]   gen_cap;
        logic [eigt_pkg::MS_W-1:0]    gen_ms;
        logic [eigt_pkg::CYC_W-1:0]   gen_cyc;
        int                           per_base;
        int                           per;
        int                           turn_left;
        int                           roll;

        for (int i = 0; i < HIST_N; i++) mdl_hist[i] = '0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.operation = eigt_pkg::OP_CAPTURE;
        in_if.capture_value = '0;
        in_if.now_ms = '0;
        in_if.now_cycles = '0;

        // after reset: zero average makes the first capture a gap
        add_typed(eigt_pkg::OP_CAPTURE, 16'h0000, 32'h0, 32'h0,
                  '{1'b1, 16'd1, 16'd0, 1'b1, 1'b0, 32'd0});
        add_typed(eigt_pkg::OP_TICK, 16'hFFFF, 32'h0, 32'hFFFF_FFFF,
                  '{1'b0, 16'd1, 16'd0, 1'b1, 1'b0, 32'd0});
        add_typed(eigt_pkg::OP_TICK, 16'h0000, 32'd6, 32'h0,
                  '{1'b0, 16'd1, 16'd0, 1'b1, 1'b1, 32'd0});
        add_typed(eigt_pkg::OP_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  '{1'b0, 16'd1, 16'd0, 1'b1, 1'b1, 32'd0});
        add_typed(eigt_pkg::OP_CAPTURE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  '{1'b1, 16'd1, 16'hFFFF, 1'b1, 1'b1, 32'd59652323});
        add_typed(eigt_pkg::OP_TICK, 16'h0000, 32'hFFFF_FFFF, 32'h0,
                  '{1'b0, 16'd1, 16'd0, 1'b1, 1'b0, 32'd59652323});
        // period wraps through zero, then a flat history and a doubled period
        add_beat(eigt_pkg::OP_CAPTURE, 16'd0, 32'd0, 32'd0);
        add_beat(eigt_pkg::OP_CAPTURE, 16'd1, 32'd1, 32'd1000);
        add_beat(eigt_pkg::OP_CAPTURE, 16'd2, 32'd2, 32'd2000);
        add_beat(eigt_pkg::OP_CAPTURE, 16'd3, 32'd3, 32'd3000);
        add_beat(eigt_pkg::OP_CAPTURE, 16'd5, 32'd4, 32'h8000_0000);
        // masked register values, zero divisor, widest timeout, unused index
        add_reg(eigt_pkg::REG_HOLES, 32'hABCD_0004);
        add_reg(eigt_pkg::REG_CYC_PER_US, 32'hFFFF_FC00);
        add_reg(eigt_pkg::REG_TIMEOUT, 32'h1234_56FF);
        add_reg(REG_SPARE, 32'hFFFF_FFFF);
        add_beat(eigt_pkg::OP_CAPTURE, 16'd6, 32'd100, 32'd10000);
        add_beat(eigt_pkg::OP_CAPTURE, 16'd7, 32'd100, 32'd11000);
        add_typed(eigt_pkg::OP_CAPTURE, 16'd9, 32'd100, 32'd12345,
                  '{1'b1, 16'd1, 16'd2, 1'b0, 1'b0, 32'hFFFF_FFFF});
        add_typed(eigt_pkg::OP_TICK, 16'd0, 32'd355, 32'd0,
                  '{1'b0, 16'd1, 16'd0, 1'b0, 1'b0, 32'hFFFF_FFFF});
        add_typed(eigt_pkg::OP_TICK, 16'd0, 32'd356, 32'd0,
                  '{1'b0, 16'd1, 16'd0, 1'b0, 1'b1, 32'hFFFF_FFFF});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                wait_drained();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
            end else begin
                send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].status);
            end
        end

        for (int seg = 0; seg < N_SEGS; seg++) begin
            wait_drained();
            src_idle_pct = (seg / 2 == 0) ? 27 : (seg / 2 == 1) ? 52 : 0;
            snk_idle_pct = (seg / 2 == 0) ? 52 : (seg / 2 == 1) ? 27 : 0;
            case (seg)
                0: begin
                    h = 16'd1;
                    t = 8'd255;
                    c = 10'd1000;
                end
                1: begin
                    h = eigt_pkg::HOLES_W'($urandom_range(12, 3));
                    t = 8'd0;
                    c = 10'd1;
                end
                2: begin
                    h = 16'hFFFF;
                    t = eigt_pkg::TMO_W'($urandom_range(255));
                    c = eigt_pkg::CPU_W'($urandom_range(1000, 1));
                end
                default: begin
                    h = eigt_pkg::HOLES_W'($urandom_range(12, 3));
                    t = eigt_pkg::TMO_W'($urandom_range(20));
                    c = eigt_pkg::CPU_W'($urandom_range(1000, 1));
                end
            endcase
            write_reg(eigt_pkg::REG_HOLES, {16'($urandom), h});
            write_reg(eigt_pkg::REG_TIMEOUT, {24'($urandom), t});
            write_reg(eigt_pkg::REG_CYC_PER_US, {22'($urandom), c});
            if (seg == 3) write_reg(REG_SPARE, $urandom);

            gen_cap = eigt_pkg::CAP_W'($urandom);
            gen_ms = $urandom;
            gen_cyc = $urandom;
            per_base = $urandom_range(15000, 40);
            turn_left = 0;
            for (int n = 0; n < SEG_ITEMS; n++) begin
                roll = $urandom_range(99);
                if (roll < 2) wait_drained();
                if (roll < 15) begin
                    // noise beat
                    b.op = eigt_pkg::t_op'($urandom_range(1));
                    b.cap = eigt_pkg::CAP_W'($urandom);
                    b.ms = $urandom;
                    b.cyc = $urandom;
                end else if (roll < 35) begin
                    // tick around the timeout
                    gen_ms = gen_ms + $urandom_range(int'(cfg_tmo) + 2);
                    b.op = eigt_pkg::OP_TICK;
                    b.cap = eigt_pkg::CAP_W'($urandom);
                    b.ms = gen_ms;
                    b.cyc = $urandom;
                end else begin
                    if (turn_left == 0) begin
                        per_base = per_base * $urandom_range(112, 88) / 100;
                        if (per_base < 40) per_base = 40;
                        if (per_base > 15000) per_base = 15000;
                        turn_left = (cfg_holes >= 3 && cfg_holes <= 12) ?
                                    int'(cfg_holes) - 1 : $urandom_range(11, 2);
                        if ($urandom_range(9) < 3) turn_left += $urandom_range(2) - 1;
                    end
                    turn_left--;
                    per = per_base + $urandom_range(per_base / 16);
                    if (turn_left == 0) per = 2 * per_base + $urandom_range(per_base / 16);
                    gen_cap = gen_cap + per[eigt_pkg::CAP_W-1:0];
                    gen_cyc = gen_cyc + per * $urandom_range(40, 1);
                    gen_ms = gen_ms + $urandom_range(3);
                    b.op = eigt_pkg::OP_CAPTURE;
                    b.cap = gen_cap;
                    b.ms = gen_ms;
                    b.cyc = gen_cyc;
                end
                send_beat(b, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
